[sv/efg_pkg.sv]
// shared constants, types and functions of the frame generator
package efg_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned TYPE_W     = 16;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned MAX_FRAME_BYTES = 2047;
  localparam int unsigned HDR_BYTES       = 22;
  localparam int unsigned FCS_BYTES       = 4;
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_BYTES);

  localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(26);
  localparam logic [LEN_W-1:0] LEN_CAP   =
    (MAX_FRAME_BYTES > (2 ** LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_FRAME_BYTES);

  localparam logic [63:0]       PREAMBLE_SFD = 64'hFB55_5555_5555_55D5;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_ONES     = 32'hFFFF_FFFF;

  localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH = LEN_W'(64);
  localparam logic [TYPE_W-1:0] RST_TYPE_FIELD   = 16'hAEFE;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_FIELD   = 3'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] src_address;
    logic [LEN_W-1:0]  frame_length;
    logic [TYPE_W-1:0] type_field;
  } efg_cfg_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W - BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/efg_if.sv]
// handshake channel interfaces of the frame generator
interface efg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface efg_out_if import efg_pkg::*;;
  logic             valid;
  logic             ready;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  byte_index;
  logic             last_of_frame;
  modport source (output valid, output out_byte, output byte_index, output last_of_frame,
                  input ready);
  modport sink (input valid, input out_byte, input byte_index, input last_of_frame,
                output ready);
endinterface

interface efg_cfg_if import efg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ethernet_frame_generator_crc32_unit.sv]
// top level of the ethernet frame generator with crc-32 trailer
// Each transfer on stream_in produces one frame byte on stream_out in the next
// cycle, and a new transfer is taken every cycle unless stream_out stalls: the
// byte selection and the byte-wide crc-32 update sit between the position/crc
// state and a single output register, which also decouples the two sides. Frames
// repeat back to back: preamble and sfd, destination, source, type, zero payload,
// then the inverted reflected crc most significant byte first; restart begins a
// new frame. Registers are written on the cfg channel, index 0 destination, 1
// source, 2 frame length, 3 type, and should change only while no byte is in flight.
module ethernet_frame_generator_crc32_unit import efg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  efg_cfg_if.sink   cfg,
  efg_in_if.sink    stream_in,
  efg_out_if.source stream_out
);

  efg_cfg_t regs;

  efg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  efg_frame_gen u_frame_gen (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .in_ch  (stream_in),
    .out_ch (stream_out)
  );

endmodule

[sv/efg_cfg_regs.sv]
// configuration register file of the frame generator
module efg_cfg_regs import efg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  efg_cfg_if.sink   cfg,
  output efg_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dest_address <= '0;
      regs.src_address  <= '0;
      regs.frame_length <= RST_FRAME_LENGTH;
      regs.type_field   <= RST_TYPE_FIELD;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DEST_ADDRESS: regs.dest_address <= cfg.data[ADDR_W-1:0];
        REG_SRC_ADDRESS:  regs.src_address  <= cfg.data[ADDR_W-1:0];
        REG_FRAME_LENGTH: regs.frame_length <= cfg.data[LEN_W-1:0];
        REG_TYPE_FIELD:   regs.type_field   <= cfg.data[TYPE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/efg_frame_gen.sv]
// frame position and crc state with the registered output byte
module efg_frame_gen import efg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  efg_cfg_t  regs,
  efg_in_if.sink    in_ch,
  efg_out_if.source out_ch
);

  logic [LEN_W-1:0]  position;
  logic [LEN_W-1:0]  position_next;
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;
  logic              out_valid;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  crc_start;
  logic              wrap;
  logic [LEN_W-1:0]  p;
  logic [CRC_W-1:0]  crc_cur;
  logic [CRC_W-1:0]  fcs;
  logic [LEN_W-1:0]  k_full;
  logic [1:0]        k;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr;
  logic [BYTE_W-1:0] hdr_byte;
  logic [BYTE_W-1:0] byte_val;
  logic              last;
  logic              accept;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  assign hdr = {PREAMBLE_SFD, regs.dest_address, regs.src_address, regs.type_field};

  always_comb begin
    len = regs.frame_length;
    if (len < MIN_FRAME) begin
      len = MIN_FRAME;
    end
    if (len > LEN_CAP) begin
      len = LEN_CAP;
    end
    crc_start = len - LEN_W'(FCS_BYTES);

    wrap    = in_ch.restart || (position >= len);
    p       = wrap ? '0 : position;
    crc_cur = wrap ? CRC_ONES : crc;

    hdr_idx  = HDR_IDX_W'(HDR_BYTES - 1) - p[HDR_IDX_W-1:0];
    hdr_byte = (p < LEN_W'(HDR_BYTES)) ? hdr[hdr_idx] : '0;

    fcs    = crc_cur ^ CRC_ONES;
    k_full = p - crc_start;
    k      = k_full[1:0];
    last   = 1'b0;

    if (p < crc_start) begin
      byte_val      = hdr_byte;
      crc_next      = crc_byte(crc_cur, hdr_byte);
      position_next = p + LEN_W'(1);
    end else begin
      unique case (k)
        2'd0: byte_val = fcs[31:24];
        2'd1: byte_val = fcs[23:16];
        2'd2: byte_val = fcs[15:8];
        2'd3: byte_val = fcs[7:0];
        default: byte_val = fcs[7:0];
      endcase
      if (k == 2'd3) begin
        last          = 1'b1;
        crc_next      = CRC_ONES;
        position_next = '0;
      end else begin
        crc_next      = crc_cur;
        position_next = p + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      crc       <= CRC_ONES;
      out_valid <= 1'b0;
    end else if (accept) begin
      position  <= position_next;
      crc       <= crc_next;
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.out_byte      <= byte_val;
      out_ch.byte_index    <= p;
      out_ch.last_of_frame <= last;
    end
  end

endmodule

[verif/tb_ethernet_frame_generator_crc32_unit.sv]
`timescale 1ns / 100ps
// testbench of the ethernet frame generator: byte stream checked against a crc-32 frame model
module tb_ethernet_frame_generator_crc32_unit;
  import efg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_TICKS = 1360;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  index;
    logic              eof;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst;

  efg_cfg_if cfg_ch();
  efg_in_if  in_ch();
  efg_out_if out_ch();

  ethernet_frame_generator_crc32_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .stream_in(in_ch),
    .stream_out(out_ch)
  );

  always #4 clk = ~clk;

  // frame model state and register copies
  logic [ADDR_W-1:0] shadow_dest;
  logic [ADDR_W-1:0] shadow_src;
  logic [LEN_W-1:0]  shadow_len;
  logic [TYPE_W-1:0] shadow_type;
  int unsigned       frame_pos;
  logic [CRC_W-1:0]  frame_crc;
  wire_byte_t        bytes_due[$];

  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned ticks_taken;
  int unsigned restarts_taken;
  int unsigned bytes_checked;
  int unsigned frames_closed;
  int unsigned quiet_cycles;
  int unsigned rx_hold;
  bit          tx_idle;
  bit          rx_idle;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
    logic fb;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic void predict_wire_byte(input logic rs);
    int unsigned len;
    int unsigned fcs_at;
    int unsigned k;
    logic [175:0] hdr;
    logic [CRC_W-1:0] fcs;
    wire_byte_t e;
    len = shadow_len;
    if (len < MIN_FRAME) len = MIN_FRAME;
    if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
    fcs_at = len - FCS_BYTES;
    if (rs || frame_pos >= len) begin
      frame_pos = 0;
      frame_crc = CRC_ONES;
    end
    e.index = frame_pos[LEN_W-1:0];
    e.eof = 1'b0;
    if (frame_pos < fcs_at) begin
      hdr = {PREAMBLE_SFD, shadow_dest, shadow_src, shadow_type};
      if (frame_pos < HDR_BYTES) e.data = hdr[175 - 8 * frame_pos -: 8];
      else e.data = '0;
      frame_crc = crc_update(frame_crc, e.data);
      frame_pos++;
    end else begin
      fcs = ~frame_crc;
      k = frame_pos - fcs_at;
      e.data = fcs[8 * (3 - k) +: 8];
      if (k == 3) begin
        e.eof = 1'b1;
        frame_pos = 0;
        frame_crc = CRC_ONES;
      end else begin
        frame_pos++;
      end
    end
    bytes_due.push_back(e);
  endfunction

  // register copies, prediction and checking, all sampled at the rising edge
  always @(posedge clk) begin
    wire_byte_t e;
    if (rst) begin
      shadow_dest = '0;
      shadow_src = '0;
      shadow_len = RST_FRAME_LENGTH;
      shadow_type = RST_TYPE_FIELD;
      frame_pos = 0;
      frame_crc = CRC_ONES;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DEST_ADDRESS: shadow_dest = cfg_ch.data[ADDR_W-1:0];
          REG_SRC_ADDRESS:  shadow_src = cfg_ch.data[ADDR_W-1:0];
          REG_FRAME_LENGTH: shadow_len = cfg_ch.data[LEN_W-1:0];
          REG_TYPE_FIELD:   shadow_type = cfg_ch.data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        ticks_taken++;
        if (in_ch.restart) restarts_taken++;
        predict_wire_byte(in_ch.restart);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: byte with none expected: byte %h index %0d last %b", $time,
                   out_ch.out_byte, out_ch.byte_index, out_ch.last_of_frame);
          errors++;
        end else begin
          e = bytes_due.pop_front();
          bytes_checked++;
          if (e.eof) frames_closed++;
          if (out_ch.out_byte !== e.data) begin
            $display("%0t: out_byte expected %h actual %h (index %0d)", $time, e.data,
                     out_ch.out_byte, e.index);
            errors++;
          end
          if (out_ch.byte_index !== e.index) begin
            $display("%0t: byte_index expected %0d actual %0d", $time, e.index,
                     out_ch.byte_index);
            errors++;
          end
          if (out_ch.last_of_frame !== e.eof) begin
            $display("%0t: last_of_frame expected %b actual %b (index %0d)", $time, e.eof,
                     out_ch.last_of_frame, e.index);
            errors++;
          end
        end
      end
    end
  end

  function automatic int unsigned draw_gap(input bit enabled);
    if (!enabled) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 8);
    return 0;
  endfunction

  // output side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_hold = draw_gap(rx_idle);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d bytes still expected", $time,
                 quiet_cycles, bytes_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic rs);
    int unsigned gap;
    gap = draw_gap(tx_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned restart_odds);
    for (int unsigned i = 0; i < n; i++) begin
      send_tick(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
    end
  endtask

  // let every outstanding byte drain before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] len_word(input int unsigned len);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'({$urandom, $urandom});
    w[LEN_W-1:0] = len[LEN_W-1:0];
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic int unsigned rand_len();
    case ($urandom_range(0, 19))
      0, 1: return $urandom_range(0, 25);
      2, 3: return $urandom_range(81, 400);
      4: return MAX_FRAME_BYTES;
      default: return $urandom_range(26, 80);
    endcase
  endfunction

  task automatic test_defaults();
    tx_idle = 0;
    rx_idle = 0;
    run_ticks(66, 0);
    settle();
  endtask

  task automatic test_field_extremes();
    write_reg(REG_DEST_ADDRESS, '1);
    write_reg(REG_SRC_ADDRESS, '0);
    write_reg(REG_TYPE_FIELD, '1);
    write_reg(REG_FRAME_LENGTH, len_word(0));
    write_reg(REG_UNUSED, '1);
    run_ticks(26, 0);
    settle();
    tx_idle = 1;
    rx_idle = 1;
    write_reg(REG_DEST_ADDRESS, '0);
    write_reg(REG_SRC_ADDRESS, '1);
    write_reg(REG_TYPE_FIELD, '0);
    write_reg(REG_FRAME_LENGTH, len_word(26));
    run_ticks(27, 0);
    settle();
  endtask

  task automatic test_short_lengths();
    write_reg(REG_FRAME_LENGTH, len_word(25));
    run_ticks(27, 0);
    settle();
    write_reg(REG_FRAME_LENGTH, len_word(1));
    run_ticks(27, 0);
    settle();
  endtask

  task automatic test_restart();
    write_reg(REG_DEST_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_FRAME_LENGTH, len_word(40));
    send_tick(1'b1);
    run_ticks(5, 0);
    send_tick(1'b1);
    run_ticks(37, 0);
    send_tick(1'b1);
    run_ticks(39, 0);
    send_tick(1'b1);
    run_ticks(3, 0);
    settle();
  endtask

  task automatic test_length_change();
    write_reg(REG_FRAME_LENGTH, len_word(100));
    run_ticks(50, 0);
    settle();
    write_reg(REG_FRAME_LENGTH, len_word(30));
    run_ticks(35, 0);
    settle();
    write_reg(REG_FRAME_LENGTH, len_word(60));
    run_ticks(40, 0);
    settle();
    write_reg(REG_FRAME_LENGTH, len_word(30));
    run_ticks(10, 0);
    settle();
    run_ticks(20, 0);
    settle();
    write_reg(REG_FRAME_LENGTH, len_word(80));
    run_ticks(70, 0);
    settle();
  endtask

  task automatic test_midframe_writes();
    write_reg(REG_FRAME_LENGTH, len_word(70));
    send_tick(1'b1);
    run_ticks(9, 0);
    settle();
    write_reg(REG_DEST_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
    run_ticks(5, 0);
    settle();
    write_reg(REG_SRC_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
    run_ticks(6, 0);
    settle();
    write_reg(REG_TYPE_FIELD, CFG_DATA_W'({$urandom, $urandom}));
    run_ticks(52, 0);
    settle();
  endtask

  task automatic test_longest_frame();
    tx_idle = 0;
    rx_idle = 0;
    write_reg(REG_FRAME_LENGTH, len_word(MAX_FRAME_BYTES));
    send_tick(1'b1);
    run_ticks(HDR_BYTES + 8, 0);
    settle();
  endtask

  task automatic test_random();
    int unsigned stop_at;
    int unsigned n_writes;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      n_writes = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n_writes; i++) begin
        case ($urandom_range(0, 8))
          0, 1: write_reg(REG_DEST_ADDRESS, rand_word());
          2, 3: write_reg(REG_SRC_ADDRESS, rand_word());
          4, 5, 6: write_reg(REG_FRAME_LENGTH, len_word(rand_len()));
          7: write_reg(REG_TYPE_FIELD, rand_word());
          default: write_reg(REG_UNUSED, rand_word());
        endcase
      end
      run_ticks($urandom_range(5, 120), $urandom_range(0, 1) ? 40 : 0);
      settle();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    errors = 0;
    ticks_sent = 0;
    ticks_taken = 0;
    restarts_taken = 0;
    bytes_checked = 0;
    frames_closed = 0;
    quiet_cycles = 0;
    tx_idle = 0;
    rx_idle = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_field_extremes();
    test_short_lengths();
    test_restart();
    test_length_change();
    test_midframe_writes();
    test_longest_frame();
    test_random();

    in_ch.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input transfers (%0d with restart), %0d bytes compared",
             ticks_taken, restarts_taken, bytes_checked);
    $display("%0d frames closed with crc trailer, %0d mismatches", frames_closed, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
